/* rtl/skt_pkg.sv */
// ----------------------------------------------------------------------------
// skt_pkg
// shared constants, codes and types of the sorted key table
// ----------------------------------------------------------------------------
package skt_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 31;
  localparam int PAY_W    = 64;
  localparam int POS_W    = 5;
  localparam int STAT_W   = 2;
  localparam int ENTRY_W  = KEY_W + PAY_W;

  localparam logic [STAT_W-1:0] ST_INSERTED  = 2'd0;
  localparam logic [STAT_W-1:0] ST_DUPLICATE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STAT_W-1:0] ST_SCAN      = 2'd3;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_SCAN   = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    logic [IDX_W-1:0] rd_addr;
  } mem_req_t;

  typedef struct packed {
    logic              valid;
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  position;
    logic [KEY_W-1:0]  entry_key;
    logic [PAY_W-1:0]  entry_payload;
    logic              last;
  } result_t;

endpackage

/* rtl/skt_ram.sv */
// ----------------------------------------------------------------------------
// skt_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module skt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/skt_ctrl.sv */
// ----------------------------------------------------------------------------
// skt_ctrl
// sequencer: binary search, shift up, insert write and key-order scan
// ----------------------------------------------------------------------------
module skt_ctrl
  import skt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             kind,
  input  logic [KEY_W-1:0] key,
  input  logic [PAY_W-1:0] payload,
  output logic             busy,
  output mem_req_t         mem_req,
  input  entry_t           rd_data,
  output result_t          result
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SREQ  = 3'd1;
  localparam logic [2:0] S_SCMP  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_INS   = 3'd4;
  localparam logic [2:0] S_SCAN  = 3'd5;

  logic [2:0]       state, state_next;
  logic [KEY_W-1:0] op_key;
  logic [PAY_W-1:0] op_payload;
  logic [CNT_W-1:0] lo, lo_next;
  logic [CNT_W-1:0] hi, hi_next;
  logic [CNT_W-1:0] idx, idx_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W:0]   mid_sum;
  logic [CNT_W-1:0] mid;
  logic [CNT_W-1:0] idx_dec;
  logic [CNT_W-1:0] idx_dec2;
  logic [CNT_W-1:0] idx_inc;
  logic [CNT_W-1:0] cnt_dec;

  assign busy     = (state != S_IDLE);
  assign mid_sum  = {1'b0, lo} + {1'b0, hi};
  assign mid      = mid_sum[CNT_W:1];
  assign idx_dec  = idx - 1'b1;
  assign idx_dec2 = idx - 2'd2;
  assign idx_inc  = idx + 1'b1;
  assign cnt_dec  = count - 1'b1;

  always_comb begin
    state_next     = state;
    lo_next        = lo;
    hi_next        = hi;
    idx_next       = idx;
    count_next     = count;
    mem_req        = '0;
    result         = '0;
    result.entry_key = op_key;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (kind == KIND_INSERT) begin
            lo_next    = '0;
            hi_next    = count;
            state_next = S_SREQ;
          end else if (count != '0) begin
            idx_next        = '0;
            mem_req.rd_addr = '0;
            state_next      = S_SCAN;
          end
        end
      end
      S_SREQ: begin
        if (lo == hi) begin
          if (count == CNT_W'(CAPACITY)) begin
            // full table, key not present
            result.valid    = 1'b1;
            result.status   = ST_FULL;
            result.position = '0;
            result.last     = 1'b1;
            state_next      = S_IDLE;
          end else if (count > lo) begin
            idx_next        = count;
            mem_req.rd_addr = cnt_dec[IDX_W-1:0];
            state_next      = S_SHIFT;
          end else begin
            state_next = S_INS;
          end
        end else begin
          idx_next        = mid;
          mem_req.rd_addr = mid[IDX_W-1:0];
          state_next      = S_SCMP;
        end
      end
      S_SCMP: begin
        if (op_key == rd_data.key) begin
          result.valid    = 1'b1;
          result.status   = ST_DUPLICATE;
          result.position = POS_W'(idx);
          result.last     = 1'b1;
          state_next      = S_IDLE;
        end else if (op_key < rd_data.key) begin
          hi_next    = idx;
          state_next = S_SREQ;
        end else begin
          lo_next    = idx_inc;
          state_next = S_SREQ;
        end
      end
      S_SHIFT: begin
        // entry idx-1 is on the read port, move it up to idx
        mem_req.we      = 1'b1;
        mem_req.wr_addr = idx[IDX_W-1:0];
        mem_req.wr_data = rd_data;
        idx_next        = idx_dec;
        if (idx_dec > lo) begin
          mem_req.rd_addr = idx_dec2[IDX_W-1:0];
        end else begin
          state_next = S_INS;
        end
      end
      S_INS: begin
        mem_req.we              = 1'b1;
        mem_req.wr_addr         = lo[IDX_W-1:0];
        mem_req.wr_data.key     = op_key;
        mem_req.wr_data.payload = op_payload;
        count_next              = count + 1'b1;
        result.valid            = 1'b1;
        result.status           = ST_INSERTED;
        result.position         = POS_W'(lo);
        result.last             = 1'b1;
        state_next              = S_IDLE;
      end
      S_SCAN: begin
        result.valid         = 1'b1;
        result.status        = ST_SCAN;
        result.position      = POS_W'(idx);
        result.entry_key     = rd_data.key;
        result.entry_payload = rd_data.payload;
        if (idx_inc == count) begin
          result.last = 1'b1;
          state_next  = S_IDLE;
        end else begin
          idx_next        = idx_inc;
          mem_req.rd_addr = idx_inc[IDX_W-1:0];
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    lo  <= lo_next;
    hi  <= hi_next;
    idx <= idx_next;
    if (state == S_IDLE && start) begin
      op_key     <= key;
      op_payload <= payload;
    end
  end

endmodule

/* rtl/sorted_key_table_insert_scan_unit.sv */
// ----------------------------------------------------------------------------
// sorted_key_table_insert_scan_unit
// sorted table of keyed entries with binary-search insert and ordered scan
// ----------------------------------------------------------------------------
// insert: a read request (S_SREQ) and a compare (S_SCMP) per search probe, then
//   S_SHIFT moves higher entries up, S_INS writes the new entry; result is registered
// scan: entries come out in key order, one per cycle, through the result register
// one command at a time: start is taken only in idle, while busy is low
// reset: rst clears the entry count and the sequencer; ram contents are kept
// results cannot be stalled: valid is high for exactly one cycle per result
module sorted_key_table_insert_scan_unit
  import skt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // command side
  input  logic              start,
  output logic              busy,
  input  logic              kind,
  input  logic [KEY_W-1:0]  key,
  input  logic [PAY_W-1:0]  payload,
  // result side
  output logic              valid,
  output logic [STAT_W-1:0] status,
  output logic [POS_W-1:0]  position,
  output logic [KEY_W-1:0]  entry_key,
  output logic [PAY_W-1:0]  entry_payload,
  output logic              last
);

  mem_req_t mem_req;
  entry_t   rd_data;
  logic [ENTRY_W-1:0] rd_word;
  result_t  result;

  // one ram holds key and payload side by side, kept in key order
  skt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_entry_ram (
    .clk     (clk),
    .we      (mem_req.we),
    .wr_addr (mem_req.wr_addr),
    .wr_data (mem_req.wr_data),
    .rd_addr (mem_req.rd_addr),
    .rd_data (rd_word)
  );

  assign rd_data = entry_t'(rd_word);

  // search / shift / scan sequencer
  skt_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .kind    (kind),
    .key     (key),
    .payload (payload),
    .busy    (busy),
    .mem_req (mem_req),
    .rd_data (rd_data),
    .result  (result)
  );

  // result register: the strobe is cleared by reset, payload just follows
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= result.valid;
    end
    status        <= result.status;
    position      <= result.position;
    entry_key     <= result.entry_key;
    entry_payload <= result.entry_payload;
    last          <= result.last;
  end

endmodule
